// ===== design/bsm_pkg.sv =====
// bsm_pkg: shared types and constants for the bounded sorted multimap
// transaction structs for both channels and the command passed front to back
// no dependencies
`default_nettype none

package bsm_pkg;

    localparam int unsigned SLOT_W      = 16;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_ADD       = 2'd0,
        KIND_GET       = 2'd1,
        KIND_CLEAR     = 2'd2,
        KIND_CLEAR_ALL = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] key;
        logic [31:0] target_id;
        logic [31:0] window_id;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] key_count;
        logic               found;
        logic               has_location;
        logic [31:0]        location_target;
        logic [31:0]        location_window;
        logic               table_full;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        logic               found;
        logic               new_key;
        logic               full;
        logic [SLOT_W-1:0]  slot;
        logic [63:0]        loc;
        logic [COUNT_W-1:0] count;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/bsm_queue.sv =====
// bsm_queue: two-entry command queue between front and back
// depends on bsm_pkg for the command type
`default_nettype none

module bsm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bsm_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output bsm_pkg::t_cmd      o_data,
    output logic               o_empty
);
    import bsm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_ok) r_wptr <= !r_wptr;
            if (pop_ok)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |=> r_count <= 2'd1) else $error("queue grew by more than one");
    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers out of step");

endmodule

`default_nettype wire

// ===== design/bsm_front.sv =====
// bsm_front: accepts transactions, looks the key up and allocates new keys
// holds the key store and key count, depends on bsm_pkg
`default_nettype none

module bsm_front #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire bsm_pkg::t_in_item i_in,
    output logic                  o_push,
    output bsm_pkg::t_cmd         o_cmd,
    input  wire logic             i_q_full
);
    import bsm_pkg::*;

    localparam int unsigned KW = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {F_IDLE, F_RD, F_CMP, F_PUSH} t_fstate;

    t_fstate       r_state;
    t_in_item      r_item;
    logic [KW:0]   r_idx;
    logic [KW:0]   r_held;
    logic [31:0]   r_kdata;
    logic          r_found;
    logic          r_new;
    logic          r_full;
    logic [KW:0]   r_slot;
    logic [31:0]   r_kmem [TABLE_ENTRIES];
    logic          scan_end;
    logic          alloc;

    assign o_in_stall = (r_state != F_IDLE);
    assign scan_end   = (r_idx == r_held);
    assign alloc      = (r_state == F_RD) && scan_end && (r_item.kind == KIND_ADD)
                        && (r_held != (KW+1)'(TABLE_ENTRIES));
    assign o_push     = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        o_cmd.kind    = r_item.kind;
        o_cmd.found   = r_found;
        o_cmd.new_key = r_new;
        o_cmd.full    = r_full;
        o_cmd.slot    = SLOT_W'(r_slot);
        o_cmd.loc     = {r_item.target_id, r_item.window_id};
        o_cmd.count   = COUNT_W'(r_held);
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_kmem[r_held[KW-1:0]] <= r_item.key;
        end
        r_kdata <= r_kmem[r_idx[KW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_held  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_new   <= 1'b0;
                        r_full  <= 1'b0;
                        r_slot  <= '0;
                        if (i_in.kind == KIND_CLEAR_ALL) begin
                            r_held  <= '0;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_RD;
                        end
                    end
                end
                F_RD: begin
                    if (scan_end) begin
                        if (r_item.kind == KIND_ADD) begin
                            if (alloc) begin
                                r_new  <= 1'b1;
                                r_slot <= r_held;
                                r_held <= r_held + 1'b1;
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                        r_state <= F_PUSH;
                    end else begin
                        r_state <= F_CMP;
                    end
                end
                F_CMP: begin
                    if (r_kdata == r_item.key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx;
                        r_state <= F_PUSH;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= F_RD;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= (KW+1)'(TABLE_ENTRIES)) else $error("key count above table size");
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(o_cmd.found && (o_cmd.new_key || o_cmd.full)))
        else $error("found key also allocated or dropped");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_CMP) |-> (r_idx < r_held)) else $error("scan past held keys");

endmodule

`default_nettype wire

// ===== design/bsm_back.sv =====
// bsm_back: carries out list operations and drives the result register
// holds list lengths and location store, depends on bsm_pkg
`default_nettype none

module bsm_back #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned LIST_DEPTH    = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [bsm_pkg::LIMIT_W-1:0]    i_list_limit,
    output logic                                o_pop,
    input  wire bsm_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_q_empty,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output bsm_pkg::t_out_item                  o_out
);
    import bsm_pkg::*;

    localparam int unsigned KW = $clog2(TABLE_ENTRIES);
    localparam int unsigned NW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned CW = (NW > LIMIT_W) ? NW : LIMIT_W;
    localparam int unsigned AW = $clog2(TABLE_ENTRIES * LIST_DEPTH);

    typedef enum logic [3:0] {
        B_IDLE, B_DISP, B_LRD, B_LCHK, B_ARD, B_ACMP, B_ATAIL, B_ERD, B_EOUT, B_RESP
    } t_bstate;

    t_bstate      r_state;
    t_cmd         r_cmd;
    logic [NW-1:0] r_idx;
    logic [NW-1:0] r_len;
    logic [NW-1:0] r_len_rd;
    logic          r_ins;
    logic [63:0]   r_carry;
    logic [63:0]   r_ldata;
    logic          r_out_valid;
    t_out_item     r_out;
    logic [NW-1:0] r_lmem [TABLE_ENTRIES];
    logic [63:0]   r_locmem [TABLE_ENTRIES * LIST_DEPTH];

    logic [KW-1:0] slot;
    logic [AW-1:0] addr;
    logic [CW-1:0] lim;
    logic          out_free;
    logic          loc_we;
    logic [63:0]   loc_wdata;
    logic          len_we;
    logic [NW-1:0] len_wdata;
    logic          e_last;
    logic          out_load;

    assign slot     = r_cmd.slot[KW-1:0];
    assign addr     = AW'(slot) * AW'(LIST_DEPTH) + AW'(r_idx);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out    = r_out;
    assign e_last   = ((r_idx + 1'b1) == r_len);
    assign out_load = ((r_state == B_EOUT) || (r_state == B_RESP)) && out_free;

    always_comb begin
        if (i_list_limit == '0) begin
            lim = CW'(1);
        end else if (CW'(i_list_limit) > CW'(LIST_DEPTH)) begin
            lim = CW'(LIST_DEPTH);
        end else begin
            lim = CW'(i_list_limit);
        end
    end

    always_comb begin
        loc_we    = 1'b0;
        loc_wdata = r_cmd.loc;
        len_we    = 1'b0;
        len_wdata = '0;
        unique case (r_state)
            B_DISP: begin
                if (r_cmd.kind == KIND_ADD && r_cmd.new_key) begin
                    loc_we    = 1'b1;
                    len_we    = 1'b1;
                    len_wdata = NW'(1);
                end else if (r_cmd.kind == KIND_CLEAR && r_cmd.found) begin
                    len_we = 1'b1;
                end
            end
            B_ACMP: begin
                if (r_ins) begin
                    loc_we    = 1'b1;
                    loc_wdata = r_carry;
                end else if (r_ldata > r_cmd.loc) begin
                    loc_we = 1'b1;
                end
            end
            B_ATAIL: begin
                if (CW'(r_len) < lim) begin
                    loc_we    = 1'b1;
                    loc_wdata = r_ins ? r_carry : r_cmd.loc;
                    len_we    = 1'b1;
                    len_wdata = r_len + 1'b1;
                end else if (r_ins) begin
                    len_we    = 1'b1;
                    len_wdata = NW'(lim);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (loc_we) r_locmem[addr] <= loc_wdata;
        r_ldata <= r_locmem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) r_lmem[slot] <= len_wdata;
        r_len_rd <= r_lmem[slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_ins   <= 1'b0;
                        r_state <= B_DISP;
                    end
                end
                B_DISP: begin
                    if (r_cmd.found && (r_cmd.kind == KIND_ADD || r_cmd.kind == KIND_GET)) begin
                        r_state <= B_LRD;
                    end else begin
                        r_state <= B_RESP;
                    end
                end
                B_LRD: r_state <= B_LCHK;
                B_LCHK: begin
                    r_len <= r_len_rd;
                    if (r_cmd.kind == KIND_GET) begin
                        r_state <= (r_len_rd == '0) ? B_RESP : B_ERD;
                    end else begin
                        r_state <= B_ARD;
                    end
                end
                B_ARD: begin
                    r_state <= (r_idx == r_len) ? B_ATAIL : B_ACMP;
                end
                B_ACMP: begin
                    if (!r_ins && r_ldata == r_cmd.loc) begin
                        r_state <= B_RESP;
                    end else begin
                        if (r_ins || r_ldata > r_cmd.loc) begin
                            r_ins   <= 1'b1;
                            r_carry <= r_ldata;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= B_ARD;
                    end
                end
                B_ATAIL: r_state <= B_RESP;
                B_ERD:   r_state <= B_EOUT;
                B_EOUT: begin
                    if (out_free) begin
                        r_out.key_count       <= r_cmd.count;
                        r_out.found           <= 1'b1;
                        r_out.has_location    <= 1'b1;
                        r_out.location_target <= r_ldata[63:32];
                        r_out.location_window <= r_ldata[31:0];
                        r_out.table_full      <= 1'b0;
                        r_out.last            <= e_last;
                        r_idx                 <= r_idx + 1'b1;
                        r_state               <= e_last ? B_IDLE : B_ERD;
                    end
                end
                B_RESP: begin
                    if (out_free) begin
                        r_out.key_count       <= r_cmd.count;
                        r_out.found           <= r_cmd.found;
                        r_out.has_location    <= 1'b0;
                        r_out.location_target <= '0;
                        r_out.location_window <= '0;
                        r_out.table_full      <= r_cmd.full;
                        r_out.last            <= 1'b1;
                        r_state               <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_has_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.has_location |-> r_out.found)
        else $error("location without found key");
    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.table_full |-> !r_out.found && !r_out.has_location)
        else $error("table full with key or location");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ARD) |-> (r_idx <= r_len) && (r_len <= NW'(LIST_DEPTH)))
        else $error("list walk out of range");

endmodule

`default_nettype wire

// ===== design/bounded_sorted_multimap.sv =====
// bounded_sorted_multimap: top level, a keyed table of bounded sorted location lists
// instantiates bsm_front, bsm_queue and bsm_back; depends on bsm_pkg
//
// input channel i_in_valid / o_in_stall carries one operation per transaction:
// add, get, clear one key or clear all. output channel o_out_valid / i_out_stall
// returns one transaction per add, clear, clear-all and get of an absent or empty
// key, and one per location for a get of a non-empty key (last marks the final one).
// the front scans the key store one held key at a time, reading and then comparing
// each; clear-all skips the scan. the back walks the list entry by entry for an add
// or a get, and every result passes through a result register. front and back
// overlap through a two-entry queue, so the front can take a new operation while
// the back still works on an earlier one; sustained throughput is set by the slower part.
// list_limit is written through i_cfg_we / i_cfg_data; the user must write it only
// while idle, and the block itself does not enforce it.
// synchronous reset empties the table and sets list_limit to 16; no clearing pass.
// when the receiver stalls, the result register holds and the back waits,
// then the queue fills and o_in_stall rises.
`default_nettype none

module bounded_sorted_multimap #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned LIST_DEPTH    = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire bsm_pkg::t_in_item           i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output bsm_pkg::t_out_item               o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [bsm_pkg::LIMIT_W-1:0] i_cfg_data
);
    import bsm_pkg::*;

    logic [LIMIT_W-1:0] r_list_limit;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    t_cmd               cmd_in;
    t_cmd               cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_list_limit <= i_cfg_data;
        end
    end

    bsm_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (push),
        .o_cmd      (cmd_in),
        .i_q_full   (q_full)
    );

    bsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (q_empty)
    );

    bsm_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .LIST_DEPTH(LIST_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_list_limit (r_list_limit),
        .o_pop        (pop),
        .i_cmd        (cmd_out),
        .i_q_empty    (q_empty),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for bounded_sorted_multimap
// drives operations from a queue, predicts results with its own table model
// depends on bsm_pkg and the bounded_sorted_multimap rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsm_pkg::*;

    localparam int NKEYS  = 256;
    localparam int DEPTH  = 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out;
    logic                i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_data = '0;

    bounded_sorted_multimap uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] tbl_key [NKEYS];
    logic        tbl_used [NKEYS];
    int          tbl_len [NKEYS];
    logic [63:0] tbl_loc [NKEYS][DEPTH];
    int          keys_now;
    logic [4:0]  limit_reg;

    t_in_item  pending_ops[$];
    t_out_item expected_results[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    logic      send_pause = 1'b0;

    function automatic int eff_limit();
        int l;
        l = limit_reg;
        if (l == 0) l = 1;
        if (l > DEPTH) l = DEPTH;
        return l;
    endfunction

    function automatic t_out_item mk_result(logic found, logic has, logic [63:0] loc,
                                            logic full, logic lst);
        t_out_item r;
        r.key_count = keys_now[8:0];
        r.found = found;
        r.has_location = has;
        r.location_target = has ? loc[63:32] : 32'd0;
        r.location_window = has ? loc[31:0] : 32'd0;
        r.table_full = full;
        r.last = lst;
        return r;
    endfunction

    task automatic add_result(t_out_item r);
        expected_results = {expected_results, r};
    endtask

    task automatic add_op(t_in_item it);
        pending_ops = {pending_ops, it};
    endtask

    task automatic insert_sorted(int s, logic [63:0] loc);
        int len, lim, pos;
        logic [63:0] tmp[DEPTH+1];
        len = tbl_len[s];
        lim = eff_limit();
        for (int i = 0; i < len; i++) if (tbl_loc[s][i] == loc) return;
        pos = len;
        for (int i = 0; i < len; i++) if (tbl_loc[s][i] > loc) begin
            pos = i;
            break;
        end
        if (len >= lim && pos == len) return;
        for (int i = 0; i < pos; i++) tmp[i] = tbl_loc[s][i];
        tmp[pos] = loc;
        for (int i = pos; i < len; i++) tmp[i+1] = tbl_loc[s][i];
        len++;
        if (len > lim) len = lim;
        for (int i = 0; i < len; i++) tbl_loc[s][i] = tmp[i];
        tbl_len[s] = len;
    endtask

    task automatic predict_op(t_in_item it);
        int s;
        logic [63:0] loc;
        s = -1;
        loc = {it.target_id, it.window_id};
        for (int i = 0; i < NKEYS; i++) if (tbl_used[i] && tbl_key[i] == it.key) begin
            s = i;
            break;
        end
        case (it.kind)
            KIND_ADD: begin
                if (s >= 0) begin
                    insert_sorted(s, loc);
                    add_result(mk_result(1, 0, 0, 0, 1));
                end else begin
                    for (int i = 0; i < NKEYS; i++) if (!tbl_used[i]) begin
                        s = i;
                        break;
                    end
                    if (s < 0) begin
                        add_result(mk_result(0, 0, 0, 1, 1));
                    end else begin
                        tbl_used[s] = 1;
                        tbl_key[s] = it.key;
                        tbl_loc[s][0] = loc;
                        tbl_len[s] = 1;
                        keys_now++;
                        add_result(mk_result(0, 0, 0, 0, 1));
                    end
                end
            end
            KIND_GET: begin
                if (s < 0) add_result(mk_result(0, 0, 0, 0, 1));
                else if (tbl_len[s] == 0) add_result(mk_result(1, 0, 0, 0, 1));
                else for (int k = 0; k < tbl_len[s]; k++)
                    add_result(mk_result(1, 1, tbl_loc[s][k], 0, k + 1 == tbl_len[s]));
            end
            KIND_CLEAR: begin
                if (s >= 0) tbl_len[s] = 0;
                add_result(mk_result(s >= 0, 0, 0, 0, 1));
            end
            default: begin
                for (int i = 0; i < NKEYS; i++) begin
                    tbl_used[i] = 0;
                    tbl_len[i] = 0;
                end
                keys_now = 0;
                add_result(mk_result(0, 0, 0, 0, 1));
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_op(i_in);
                void'(pending_ops.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_ops.size() > 0 && !send_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in <= pending_ops[0];
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_out.key_count !== e.key_count) begin
                    $error("key_count exp %0d got %0d", e.key_count, o_out.key_count);
                    errors++;
                end
                if (o_out.found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_out.found);
                    errors++;
                end
                if (o_out.has_location !== e.has_location) begin
                    $error("has_location exp %0d got %0d", e.has_location,
                           o_out.has_location);
                    errors++;
                end
                if (o_out.location_target !== e.location_target) begin
                    $error("location_target exp %h got %h", e.location_target,
                           o_out.location_target);
                    errors++;
                end
                if (o_out.location_window !== e.location_window) begin
                    $error("location_window exp %h got %h", e.location_window,
                           o_out.location_window);
                    errors++;
                end
                if (o_out.table_full !== e.table_full) begin
                    $error("table_full exp %0d got %0d", e.table_full, o_out.table_full);
                    errors++;
                end
                if (o_out.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_out.last);
                    errors++;
                end
            end
        end
    end

    function automatic t_in_item mk_op(t_kind k, logic [31:0] key, logic [31:0] t,
                                       logic [31:0] w);
        t_in_item it;
        it.kind = k;
        it.key = key;
        it.target_id = t;
        it.window_id = w;
        return it;
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        limit_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item rand_op();
        int r;
        logic [31:0] key, t, w;
        r = $urandom_range(99);
        key = ($urandom_range(9) == 0) ? $urandom : 32'hA000_0000 + $urandom_range(11);
        t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
        w = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        if ($urandom_range(15) == 0) begin
            t = (32'($urandom_range(1)) << 31) | 32'($urandom_range(7));
            w = (32'($urandom_range(1)) << 31) | 32'($urandom_range(3));
        end
        if (r < 60) return mk_op(KIND_ADD, key, t, w);
        if (r < 88) return mk_op(KIND_GET, key, 0, 0);
        if (r < 98) return mk_op(KIND_CLEAR, key, 0, 0);
        return mk_op(KIND_CLEAR_ALL, $urandom, $urandom, $urandom);
    endfunction

    initial begin
        for (int i = 0; i < NKEYS; i++) begin
            tbl_used[i] = 0;
            tbl_len[i] = 0;
        end
        keys_now = 0;
        limit_reg = LIMIT_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ordering, duplicates, clears
        add_op(mk_op(KIND_GET, 32'h0, 0, 0));
        add_op(mk_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_op(mk_op(KIND_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0));
        add_op(mk_op(KIND_ADD, 32'hFFFF_FFFF, 32'h5, 32'h9));
        add_op(mk_op(KIND_ADD, 32'hFFFF_FFFF, 32'h5, 32'h2));
        add_op(mk_op(KIND_ADD, 32'hFFFF_FFFF, 32'h5, 32'h2));
        add_op(mk_op(KIND_GET, 32'hFFFF_FFFF, 0, 0));
        add_op(mk_op(KIND_ADD, 32'h0, 32'h1234, 32'h5678));
        add_op(mk_op(KIND_CLEAR, 32'h0, 0, 0));
        add_op(mk_op(KIND_GET, 32'h0, 0, 0));
        add_op(mk_op(KIND_CLEAR, 32'h7, 0, 0));
        add_op(mk_op(KIND_ADD, 32'h0, 32'h1, 32'h1));
        add_op(mk_op(KIND_GET, 32'h0, 0, 0));
        add_op(mk_op(KIND_CLEAR_ALL, 0, 0, 0));
        add_op(mk_op(KIND_GET, 32'hFFFF_FFFF, 0, 0));
        drain();

        // limit of one and of zero, an over-range limit, then lowered below an existing list
        write_limit(5'd1);
        add_op(mk_op(KIND_ADD, 32'h55, 32'h9, 32'h0));
        add_op(mk_op(KIND_ADD, 32'h55, 32'hA, 32'h0));
        add_op(mk_op(KIND_ADD, 32'h55, 32'h3, 32'h0));
        add_op(mk_op(KIND_GET, 32'h55, 0, 0));
        drain();
        write_limit(5'd0);
        add_op(mk_op(KIND_ADD, 32'h55, 32'h1, 32'h0));
        add_op(mk_op(KIND_GET, 32'h55, 0, 0));
        drain();
        write_limit(5'd31);
        for (int i = 0; i < 18; i++)
            add_op(mk_op(KIND_ADD, 32'h66, 32'd40 - i, i));
        add_op(mk_op(KIND_GET, 32'h66, 0, 0));
        drain();
        write_limit(5'd2);
        add_op(mk_op(KIND_ADD, 32'h66, 32'hFFFF_FFFF, 0));
        add_op(mk_op(KIND_ADD, 32'h66, 32'h0, 0));
        add_op(mk_op(KIND_GET, 32'h66, 0, 0));
        drain();

        // random phases
        for (int ph = 0; ph < 3; ph++) begin
            write_limit(ph == 0 ? 5'd4 : (ph == 1 ? 5'd16 : 5'd7));
            send_idle_pct = (ph == 0) ? 27 : (ph == 1 ? 85 : 0);
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1 ? 27 : 0);
            for (int i = 0; i < 60; i++) add_op(rand_op());
            if (ph == 2) begin
                hold_cycles = 600;
                while (pending_ops.size() > 40) @(posedge i_clk);
                send_pause = 1'b1;
                while (expected_results.size() > 0 || i_in_valid) @(posedge i_clk);
                send_pause = 1'b0;
            end
            drain();
        end
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
